@@ rtl/fractional_delay_allpass_defines.svh @@
// assertion macros for the fractional delay allpass block
// used by the port checker; expects clk and rst_n in scope
`ifndef FRACTIONAL_DELAY_ALLPASS_DEFINES_SVH
`define FRACTIONAL_DELAY_ALLPASS_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define FDAP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define FDAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fdap_pkg.sv @@
// shared widths, register codes and types for the fractional delay allpass
// no dependencies
package fdap_pkg;

  localparam int LINE_DEPTH_DEF = 4096;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int SAMPLE_W   = 24;
  localparam int OFFSET_W   = 22;
  localparam int BASE_W     = 20;
  localparam int GAIN_W     = 16;
  localparam int LINE_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam int GAIN_SHIFT = 15;
  localparam logic signed [GAIN_W-1:0] GAIN_MAX = 16'sd32440;
  localparam logic signed [GAIN_W-1:0] GAIN_MIN = -16'sd32440;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 2'd1;

  typedef struct packed {
    logic [BASE_W-1:0]        base_delay;
    logic signed [GAIN_W-1:0] gain;
  } fdap_cfg_t;

  typedef struct packed {
    logic en;
    logic we;
  } fdap_mem_cmd_t;

endpackage

@@ rtl/fdap_cfg.sv @@
// configuration registers: base delay and allpass coefficient, clamped on write
// depends on fdap_pkg
module fdap_cfg #(
  parameter int LINE_DEPTH = fdap_pkg::LINE_DEPTH_DEF,
  parameter int FRAC_BITS  = fdap_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fdap_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fdap_pkg::CFG_DATA_W-1:0]   cfg_data,
  output fdap_pkg::fdap_cfg_t               cfg
);
  import fdap_pkg::*;

  localparam int AW    = $clog2(LINE_DEPTH);
  localparam int CMP_W = (AW + FRAC_BITS + 1 > BASE_W + 1) ? AW + FRAC_BITS + 1 : BASE_W + 1;
  localparam logic [CMP_W-1:0] BASE_LO = CMP_W'(longint'(1) << FRAC_BITS);
  localparam logic [CMP_W-1:0] BASE_HI = CMP_W'(longint'(LINE_DEPTH - 4) << FRAC_BITS);

  logic [BASE_W-1:0]        base_r;
  logic signed [GAIN_W-1:0] gain_r;
  logic [CMP_W-1:0]         data_ext;
  logic [CMP_W-1:0]         base_c;
  logic signed [GAIN_W-1:0] gain_in;
  logic signed [GAIN_W-1:0] gain_c;

  assign cfg_ready = 1'b1;
  assign data_ext  = CMP_W'(cfg_data[BASE_W-1:0]);
  assign gain_in   = $signed(cfg_data[GAIN_W-1:0]);

  always_comb begin
    if (data_ext < BASE_LO) begin
      base_c = BASE_LO;
    end else if (data_ext > BASE_HI) begin
      base_c = BASE_HI;
    end else begin
      base_c = data_ext;
    end
    if (gain_in > GAIN_MAX) begin
      gain_c = GAIN_MAX;
    end else if (gain_in < GAIN_MIN) begin
      gain_c = GAIN_MIN;
    end else begin
      gain_c = gain_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_W'(longint'(1) << FRAC_BITS);
      gain_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASE_DELAY:    base_r <= base_c[BASE_W-1:0];
        CFG_FEEDBACK_GAIN: gain_r <= gain_c;
        default: ;
      endcase
    end
  end

  assign cfg.base_delay = base_r;
  assign cfg.gain       = gain_r;

endmodule

@@ rtl/fdap_line_mem.sv @@
// single-port delay line memory, one access per cycle, registered read data
// depends on fdap_pkg
module fdap_line_mem #(
  parameter int LINE_DEPTH = fdap_pkg::LINE_DEPTH_DEF,
  parameter int ADDR_W     = $clog2(LINE_DEPTH)
) (
  input  logic                          clk,
  input  fdap_pkg::fdap_mem_cmd_t       cmd,
  input  logic [ADDR_W-1:0]             addr,
  input  logic [fdap_pkg::LINE_W-1:0]   wdata,
  output logic [fdap_pkg::LINE_W-1:0]   rdata
);
  import fdap_pkg::*;

  logic [LINE_W-1:0] line_mem_r [LINE_DEPTH];
  logic [LINE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      if (cmd.we) begin
        line_mem_r[addr] <= wdata;
      end else begin
        rdata_r <= line_mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/fdap_core.sv @@
// sequencer and arithmetic: delay clamp, tap addressing, interpolation,
// allpass products and saturation; drives the line memory; depends on fdap_pkg
module fdap_core #(
  parameter int LINE_DEPTH = fdap_pkg::LINE_DEPTH_DEF,
  parameter int FRAC_BITS  = fdap_pkg::FRAC_BITS_DEF,
  parameter int ADDR_W     = $clog2(LINE_DEPTH)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [fdap_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic signed [fdap_pkg::OFFSET_W-1:0] in_delay_offset,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fdap_pkg::SAMPLE_W-1:0] out_sample_out,
  input  fdap_pkg::fdap_cfg_t                 cfg,
  output fdap_pkg::fdap_mem_cmd_t             mem_cmd,
  output logic [ADDR_W-1:0]                   mem_addr,
  output logic [fdap_pkg::LINE_W-1:0]         mem_wdata,
  input  logic [fdap_pkg::LINE_W-1:0]         mem_rdata
);
  import fdap_pkg::*;

  localparam int TOT_W  = (ADDR_W + FRAC_BITS + 2 > OFFSET_W + 1) ?
                          ADDR_W + FRAC_BITS + 2 : OFFSET_W + 1;
  localparam int PROD_W = FRAC_BITS + LINE_W + 2;
  localparam int MUL_W  = GAIN_W + LINE_W;

  localparam logic signed [TOT_W-1:0]  TOT_LO    = TOT_W'(longint'(1) << FRAC_BITS);
  localparam logic signed [TOT_W-1:0]  TOT_HI    = TOT_W'(longint'(LINE_DEPTH - 2) << FRAC_BITS);
  localparam logic signed [PROD_W-1:0] INT_HALF  = PROD_W'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [MUL_W-1:0]  GAIN_HALF = MUL_W'(longint'(1) << (GAIN_SHIFT - 1));
  localparam logic [ADDR_W:0]          DEPTH_EXT = (ADDR_W + 1)'(LINE_DEPTH);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_RD0   = 4'd2;
  localparam logic [3:0] ST_RD1   = 4'd3;
  localparam logic [3:0] ST_INTP  = 4'd4;
  localparam logic [3:0] ST_GMUL  = 4'd5;
  localparam logic [3:0] ST_VSUM  = 4'd6;
  localparam logic [3:0] ST_WRITE = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0]                 state_r, state_nxt;
  logic [ADDR_W-1:0]          clr_addr_r;
  logic [ADDR_W-1:0]          w_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_data_r;

  logic signed [SAMPLE_W-1:0] x_r;
  logic [ADDR_W-1:0]          dint_r;
  logic [FRAC_BITS-1:0]       frac_r;
  logic signed [LINE_W-1:0]   t0_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [LINE_W-1:0]   delayed_r;
  logic signed [MUL_W-1:0]    gp_r;
  logic signed [LINE_W-1:0]   v_r;
  logic signed [MUL_W-1:0]    gv_r;

  logic signed [GAIN_W-1:0]   gain;
  logic signed [TOT_W-1:0]    base_ext, off_ext, tot_w, tot_c;
  logic [ADDR_W:0]            rd0_diff, rd1_diff;
  logic [ADDR_W-1:0]          rd0_addr, rd1_addr;
  logic                       w_last;
  logic                       accept;
  logic                       out_load;
  logic signed [LINE_W:0]     diff_c;
  logic signed [PROD_W-1:0]   prod_rnd;
  logic [LINE_W:0]            delayed_sum;
  logic signed [LINE_W-1:0]   delayed_c;
  logic signed [MUL_W-1:0]    gp_rnd, gv_rnd;
  logic [LINE_W+1:0]          v_w, y_w;
  logic signed [LINE_W-1:0]   v_sat;
  logic signed [SAMPLE_W-1:0] y_sat;

  assign gain     = cfg.gain;
  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // total delay, clamped to one sample .. depth minus two
  assign base_ext = {{(TOT_W - BASE_W){1'b0}}, cfg.base_delay};
  assign off_ext  = {{(TOT_W - OFFSET_W){in_delay_offset[OFFSET_W-1]}}, in_delay_offset};
  assign tot_w    = base_ext + off_ext;

  always_comb begin
    if (tot_w < TOT_LO) begin
      tot_c = TOT_LO;
    end else if (tot_w > TOT_HI) begin
      tot_c = TOT_HI;
    end else begin
      tot_c = tot_w;
    end
  end

  // tap addresses behind the write pointer, wrapped once
  assign rd0_diff = {1'b0, w_r} - {1'b0, dint_r};
  assign rd1_diff = {1'b0, w_r} - {1'b0, dint_r} - (ADDR_W + 1)'(1);
  assign rd0_addr = rd0_diff[ADDR_W] ? ADDR_W'(rd0_diff + DEPTH_EXT) : rd0_diff[ADDR_W-1:0];
  assign rd1_addr = rd1_diff[ADDR_W] ? ADDR_W'(rd1_diff + DEPTH_EXT) : rd1_diff[ADDR_W-1:0];
  assign w_last   = (w_r == ADDR_W'(LINE_DEPTH - 1));

  // interpolation between the two taps, round half up
  assign diff_c      = {mem_rdata[LINE_W-1], mem_rdata} - {t0_r[LINE_W-1], t0_r};
  assign prod_rnd    = (prod_r + INT_HALF) >>> FRAC_BITS;
  assign delayed_sum = {t0_r[LINE_W-1], t0_r} + prod_rnd[LINE_W:0];
  assign delayed_c   = delayed_sum[LINE_W-1:0];

  assign gp_rnd = (gp_r + GAIN_HALF) >>> GAIN_SHIFT;
  assign gv_rnd = (gv_r + GAIN_HALF) >>> GAIN_SHIFT;
  assign v_w    = {{(LINE_W + 2 - SAMPLE_W){x_r[SAMPLE_W-1]}}, x_r}
                + {gp_rnd[LINE_W], gp_rnd[LINE_W:0]};
  assign y_w    = {{2{delayed_r[LINE_W-1]}}, delayed_r}
                - {gv_rnd[LINE_W], gv_rnd[LINE_W:0]};

  always_comb begin
    if ((&v_w[LINE_W+1:LINE_W-1]) || !(|v_w[LINE_W+1:LINE_W-1])) begin
      v_sat = v_w[LINE_W-1:0];
    end else if (v_w[LINE_W+1]) begin
      v_sat = {1'b1, {(LINE_W-1){1'b0}}};
    end else begin
      v_sat = {1'b0, {(LINE_W-1){1'b1}}};
    end
    if ((&y_w[LINE_W+1:SAMPLE_W-1]) || !(|y_w[LINE_W+1:SAMPLE_W-1])) begin
      y_sat = y_w[SAMPLE_W-1:0];
    end else if (y_w[LINE_W+1]) begin
      y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // sequencer and memory port
  always_comb begin
    state_nxt = state_r;
    mem_cmd   = '0;
    mem_addr  = w_r;
    mem_wdata = v_r;
    case (state_r)
      ST_CLEAR: begin
        mem_cmd.en = 1'b1;
        mem_cmd.we = 1'b1;
        mem_addr   = clr_addr_r;
        mem_wdata  = '0;
        if (clr_addr_r == ADDR_W'(LINE_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RD0;
      end
      ST_RD0: begin
        mem_cmd.en = 1'b1;
        mem_addr   = rd0_addr;
        state_nxt  = ST_RD1;
      end
      ST_RD1: begin
        mem_cmd.en = 1'b1;
        mem_addr   = rd1_addr;
        state_nxt  = ST_INTP;
      end
      ST_INTP:  state_nxt = ST_GMUL;
      ST_GMUL:  state_nxt = ST_VSUM;
      ST_VSUM:  state_nxt = ST_WRITE;
      ST_WRITE: begin
        mem_cmd.en = 1'b1;
        mem_cmd.we = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      w_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (state_r == ST_WRITE) w_r <= w_last ? '0 : w_r + ADDR_W'(1);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= in_sample_in;
      dint_r <= tot_c[FRAC_BITS +: ADDR_W];
      frac_r <= tot_c[FRAC_BITS-1:0];
    end
    if (state_r == ST_RD1) t0_r <= mem_rdata;
    if (state_r == ST_INTP) prod_r <= $signed({1'b0, frac_r}) * diff_c;
    if (state_r == ST_GMUL) begin
      delayed_r <= delayed_c;
      gp_r      <= gain * delayed_c;
    end
    if (state_r == ST_VSUM) v_r <= v_sat;
    if (state_r == ST_WRITE) gv_r <= gain * v_r;
    if (out_load) out_data_r <= y_sat;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

endmodule

@@ rtl/fractional_delay_allpass.sv @@
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_ready   | in_sample_in (s24), in_delay_offset (s22)
// out     | output    | out_valid/out_ready | out_sample_out (s24)
// cfg     | input     | cfg_valid/cfg_ready | cfg_index (2), cfg_data (20)
//
// each transaction steps through RD0, RD1, INTP, GMUL, VSUM, WRITE and OUT to the
// result register, and the next is accepted only back in idle: two tap reads, one
// write-back on the single memory port and three chained multiplies.
// after reset the line is zeroed one entry per cycle, all LINE_DEPTH entries (4096 by
// default), with in_ready low; configuration writes are taken at any time.
// a held result stalls the sequencer before its last step; the next transaction is
// accepted while a finished result waits in the output register.
module fractional_delay_allpass #(
  parameter int LINE_DEPTH = fdap_pkg::LINE_DEPTH_DEF,
  parameter int FRAC_BITS  = fdap_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [fdap_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic signed [fdap_pkg::OFFSET_W-1:0] in_delay_offset,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [fdap_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fdap_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fdap_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import fdap_pkg::*;

  localparam int ADDR_W = $clog2(LINE_DEPTH);

  fdap_cfg_t         cfg;
  fdap_mem_cmd_t     mem_cmd;
  logic [ADDR_W-1:0] mem_addr;
  logic [LINE_W-1:0] mem_wdata;
  logic [LINE_W-1:0] mem_rdata;

  fdap_cfg #(
    .LINE_DEPTH (LINE_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fdap_line_mem #(
    .LINE_DEPTH (LINE_DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  fdap_core #(
    .LINE_DEPTH (LINE_DEPTH),
    .FRAC_BITS  (FRAC_BITS),
    .ADDR_W     (ADDR_W)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_in    (in_sample_in),
    .in_delay_offset (in_delay_offset),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample_out  (out_sample_out),
    .cfg             (cfg),
    .mem_cmd         (mem_cmd),
    .mem_addr        (mem_addr),
    .mem_wdata       (mem_wdata),
    .mem_rdata       (mem_rdata)
  );

endmodule

@@ rtl/fdap_checker.sv @@
// port-level checks on the fractional delay allpass, bound to the top level
// depends on fractional_delay_allpass_defines.svh
`include "fractional_delay_allpass_defines.svh"

module fdap_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_sample_out
);

  // a stalled result holds its value
  `FDAP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample_out), "result changed while stalled")

  // one transaction in flight: the sequencer stays busy through both tap reads and the interpolation step
  `FDAP_ASSERT_SAME(a_busy_after_accept, in_valid && in_ready, ##1 !in_ready ##1 !in_ready ##1 !in_ready, "transaction accepted while busy")

  // a fresh result is loaded as the sequencer returns to idle
  `FDAP_ASSERT_SAME(a_ready_on_result, $rose(out_valid), in_ready, "result appeared without idle sequencer")

endmodule

bind fractional_delay_allpass fdap_checker u_fdap_checker (.*);
